// ===== rtl/core/oust_pkg.sv =====
// ----------------------------------------------------------------------------
// oust_pkg
// Shared types and codes for the ordered unique set table.
// ----------------------------------------------------------------------------
package oust_pkg;

  localparam int CMD_W   = 2;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  // command codes; code three is a no-op
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the input word
    logic exec;   // search, update table, load result register
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;  // result register full and not drained this cycle
  } dp_sts_t;

endpackage

// ===== rtl/core/oust_ctrl.sv =====
// ----------------------------------------------------------------------------
// oust_ctrl
// Two-state sequencer: capture a word, then execute it once the result
// register can take the answer.
// ----------------------------------------------------------------------------
module oust_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  oust_pkg::dp_sts_t sts,
  output oust_pkg::ctl_t    ctl
);
  import oust_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.out_busy) begin
          ctl.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/oust_dp.sv =====
// ----------------------------------------------------------------------------
// oust_dp
// Entry row with per-cell compare, append and close-the-gap shift, plus the
// result register.
// ----------------------------------------------------------------------------
module oust_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  oust_pkg::ctl_t                       ctl,
  output oust_pkg::dp_sts_t                    sts,
  input  logic [oust_pkg::CMD_W-1:0]           command,
  input  logic signed [oust_pkg::VALUE_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [oust_pkg::STAT_W-1:0]          status,
  output logic                                found,
  output logic [oust_pkg::POS_W-1:0]           position,
  output logic [oust_pkg::COUNT_W-1:0]         count
);
  import oust_pkg::*;

  localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PXW = (IW > POS_W) ? IW : POS_W;
  localparam int CXW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [CMD_W-1:0]   cmd_q;
  logic [VALUE_W-1:0] value_q;
  logic [VALUE_W-1:0] entries [CAPACITY];
  logic [CW-1:0]      entry_count;
  logic [CW-1:0]      entry_count_next;

  logic [CAPACITY-1:0] hit;
  logic [CAPACITY-1:0] app_sel;
  logic [CAPACITY-1:0] shift_sel;
  logic [IW-1:0]       idx;
  logic                hit_any;
  logic                full;
  logic                do_add;
  logic                do_rem;
  logic [STAT_W-1:0]   status_next;
  logic                found_next;
  logic [PXW-1:0]      pos_ext;
  logic [CXW-1:0]      cnt_ext;

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= command;
      value_q <= value;
    end
  end

  // per-cell match and write selects
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign hit[i]       = (CW'(i) < entry_count) && (entries[i] == value_q);
    assign app_sel[i]   = (entry_count == CW'(i));
    assign shift_sel[i] = (IW'(i) >= idx);

    if (i < CAPACITY - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (ctl.exec && do_add && app_sel[i]) begin
          entries[i] <= value_q;
        end else if (ctl.exec && do_rem && shift_sel[i]) begin
          entries[i] <= entries[i+1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (ctl.exec && do_add && app_sel[i]) begin
          entries[i] <= value_q;
        end
      end
    end
  end

  // values are unique, so at most one hit: OR-encode
  always_comb begin
    idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

  assign hit_any = |hit;
  assign full    = (entry_count == CW'(CAPACITY));

  always_comb begin
    do_add           = 1'b0;
    do_rem           = 1'b0;
    found_next       = hit_any;
    status_next      = ST_NONE;
    entry_count_next = entry_count;
    unique case (cmd_q)
      CMD_ADD: begin
        if (hit_any) begin
          status_next = ST_NONE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          do_add           = 1'b1;
          status_next      = ST_DONE;
          entry_count_next = entry_count + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (hit_any) begin
          do_rem           = 1'b1;
          status_next      = ST_DONE;
          entry_count_next = entry_count - CW'(1);
        end
      end
      CMD_CHECK: begin
        status_next = hit_any ? ST_DONE : ST_NONE;
      end
      default: begin
        found_next = 1'b0;
      end
    endcase
  end

  assign pos_ext = found_next ? PXW'(idx) : '0;
  assign cnt_ext = CXW'(entry_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (ctl.exec) begin
        entry_count <= entry_count_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      status   <= status_next;
      found    <= found_next;
      position <= pos_ext[POS_W-1:0];
      count    <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign sts.out_busy = out_valid && !out_ready;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_unique_hit: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |-> $onehot0(hit))
    else $error("value stored more than once");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && do_add) |=> (entry_count == $past(entry_count) + CW'(1)))
    else $error("append did not grow the table");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.exec |-> !(out_valid && !out_ready))
    else $error("result register overwritten while held");
`endif

endmodule

// ===== rtl/core/ordered_unique_set_table.sv =====
// ----------------------------------------------------------------------------
// ordered_unique_set_table
// Bounded table of unique 32-bit values kept in insertion order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word: command and value.
//   command: add appends an absent value, remove deletes a present value and
//   closes the gap, check looks the value up; code three does nothing.
//   Output channel (out_valid/out_ready) returns one word per input word:
//   status, found flag, position of the value and the entry count after
//   the operation.
// Timing:
//   A word is captured on acceptance; once the result register can take
//   the answer, every entry is compared in parallel, the table is updated
//   (append or one-step shift) and the result register loads. The
//   capture/execute sequencer takes no new word until the captured one
//   has executed; in_ready is low from acceptance until the word
//   executes, which waits while the result register is still held. A new
//   word is taken while a result still waits in the output register.
// Stall: if the receiver holds out_ready low, execution of the next word
//   waits until the pending result drains; no result is dropped.
// Reset: rst (synchronous) empties the table and clears out_valid.
// ----------------------------------------------------------------------------
module ordered_unique_set_table #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [oust_pkg::CMD_W-1:0]           command,
  input  logic signed [oust_pkg::VALUE_W-1:0]  value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [oust_pkg::STAT_W-1:0]          status,
  output logic                                found,
  output logic [oust_pkg::POS_W-1:0]           position,
  output logic [oust_pkg::COUNT_W-1:0]         count
);
  import oust_pkg::*;

  ctl_t    ctl;
  dp_sts_t sts;

  // sequencer: capture, then execute
  oust_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // entry row, compare/shift logic and result register
  oust_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .command   (command),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .found     (found),
    .position  (position),
    .count     (count)
  );

endmodule
